@@ rtl/core/elpc_pkg.sv @@
// Shared constants, types and elaboration-time functions for the ellipse point and containment block.
package elpc_pkg;

	localparam int CORDIC_STAGES    = 16;
	localparam int SECTORS_PER_TURN = 12;

	localparam int IDX_W   = 16;
	localparam int PREC_W  = 8;
	localparam int COORD_W = 32;
	localparam int RAD_W   = 31;
	localparam int PH_W    = 32;
	localparam int Q_W     = PH_W - 2;
	localparam int NUM_W   = IDX_W + PH_W;
	localparam int CNT_W   = $clog2(SECTORS_PER_TURN * 255 + 1);
	localparam int SH_W    = $clog2(CORDIC_STAGES);
	localparam int XY_W    = 34;
	localparam int T_W     = XY_W + 1;
	localparam int Z_W     = 64;
	localparam int CONT_LAT = 7;

	localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic [31:0] TWO_PI_HI = 32'h6487ED51;
	localparam logic [31:0] TWO_PI_LO = 32'h10B4611A;
	localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;

	// Configuration register indexes
	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_RADIUS_X = 2'd2;
	localparam logic [1:0] REG_RADIUS_Y = 2'd3;

	// Item flags carried alongside the datapath
	typedef struct packed {
		logic valid;
		logic mode;
		logic hit;
	} tag_t;

	// Divider cell state: dividend shifts out, quotient shifts in
	typedef struct packed {
		tag_t             tag;
		logic [NUM_W-1:0] num;
		logic [CNT_W-1:0] rem;
		logic [CNT_W-1:0] count;
	} div_t;

	// CORDIC cell state
	typedef struct packed {
		tag_t                    tag;
		logic [1:0]              quad;
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [Z_W-1:0]   z;
	} cord_t;

	// Shift-subtract long division, constants only
	function automatic logic [63:0] udiv_c(logic [63:0] n, logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Arctangent of 2^-i in Q60 by truncated series
	function automatic logic signed [63:0] atan_q60(int i);
		logic signed [63:0] sum;
		logic [63:0] t;
		sum = '0;
		if (i == 0) begin
			return $signed(PI_Q60 >> 2);
		end
		for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
			t = udiv_c(64'd1 << (60 - i * (2 * k + 1)), 64'(2 * k + 1));
			if (k[0]) sum = sum - $signed(t);
			else sum = sum + $signed(t);
		end
		return sum;
	endfunction

endpackage

@@ rtl/core/elpc_div_cell.sv @@
// One restoring division cell: develops one quotient bit of the turn phase per cycle.
module elpc_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  elpc_pkg::div_t d_i,
	output elpc_pkg::div_t d_o
);

	logic [elpc_pkg::CNT_W:0] rem2;
	logic                     qbit;
	elpc_pkg::div_t           nxt;

	// Shift in next dividend bit, trial subtract
	always_comb begin
		rem2 = {d_i.rem, d_i.num[elpc_pkg::NUM_W-1]};
		qbit = (rem2 >= {1'b0, d_i.count});
		nxt  = d_i;
		nxt.num = {d_i.num[elpc_pkg::NUM_W-2:0], qbit};
		nxt.rem = qbit ? elpc_pkg::CNT_W'(rem2 - {1'b0, d_i.count})
		               : rem2[elpc_pkg::CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_o <= '0;
		end else begin
			d_o <= nxt;
		end
	end

endmodule

@@ rtl/core/elpc_cordic_cell.sv @@
// One CORDIC rotation cell in rotation mode.
module elpc_cordic_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  elpc_pkg::cord_t                    c_i,
	input  logic [elpc_pkg::SH_W-1:0]          sh,
	input  logic signed [elpc_pkg::Z_W-1:0]    atan,
	output elpc_pkg::cord_t                    c_o
);

	logic signed [elpc_pkg::XY_W-1:0] dx;
	logic signed [elpc_pkg::XY_W-1:0] dy;
	elpc_pkg::cord_t                  nxt;

	// Rotate towards zero residual angle
	always_comb begin
		dx  = c_i.y >>> sh;
		dy  = c_i.x >>> sh;
		nxt = c_i;
		if (!c_i.z[elpc_pkg::Z_W-1]) begin
			nxt.x = c_i.x - dx;
			nxt.y = c_i.y + dy;
			nxt.z = c_i.z - atan;
		end else begin
			nxt.x = c_i.x + dx;
			nxt.y = c_i.y - dy;
			nxt.z = c_i.z + atan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_o <= '0;
		end else begin
			c_o <= nxt;
		end
	end

endmodule

@@ rtl/core/elpc_scale.sv @@
// Four-stage lane: center + radius * trig / 2^30, rounded, saturated to Q16.16.
module elpc_scale (
	input  logic                                 clk,
	input  logic [elpc_pkg::RAD_W-1:0]           r,
	input  logic signed [elpc_pkg::T_W-1:0]      t,
	input  logic signed [elpc_pkg::COORD_W-1:0]  center,
	output logic signed [elpc_pkg::COORD_W-1:0]  pt
);

	logic [46:0]         plo_s1, plo_s2;
	logic signed [18:0]  th_s1;
	logic signed [50:0]  phi_s2;
	logic signed [37:0]  sc_s3;
	logic signed [67:0]  sum;
	logic signed [38:0]  v;
	logic signed [elpc_pkg::COORD_W-1:0] pt_s4;

	// Rounded sum of partial products, then add center and clamp
	always_comb begin
		sum = {phi_s2[50], phi_s2, 16'b0} + {21'b0, plo_s2} + 68'sd536870912;
		v   = {{7{center[31]}}, center} + {sc_s3[37], sc_s3};
	end

	always_ff @(posedge clk) begin
		plo_s1 <= r * t[15:0];
		th_s1  <= t[elpc_pkg::T_W-1:16];
		phi_s2 <= $signed({1'b0, r}) * th_s1;
		plo_s2 <= plo_s1;
		sc_s3  <= sum[67:30];
		if (v > 39'sh007FFFFFFF) pt_s4 <= 32'sh7FFFFFFF;
		else if (v < -39'sh0080000000) pt_s4 <= 32'sh80000000;
		else pt_s4 <= v[31:0];
	end

	assign pt = pt_s4;

endmodule

@@ rtl/core/elpc_contain.sv @@
// Seven-stage containment test: bounding box and exact 124-bit quadratic compare.
module elpc_contain (
	input  logic                                 clk,
	input  logic signed [elpc_pkg::COORD_W-1:0]  qx,
	input  logic signed [elpc_pkg::COORD_W-1:0]  qy,
	input  logic signed [elpc_pkg::COORD_W-1:0]  cx,
	input  logic signed [elpc_pkg::COORD_W-1:0]  cy,
	input  logic [elpc_pkg::RAD_W-1:0]           rx,
	input  logic [elpc_pkg::RAD_W-1:0]           ry,
	output logic                                 hit
);

	logic [32:0]  dx, dy, adx, ady;
	logic [30:0]  a_s1, b_s1;
	logic         ok_s1, ok_s2, ok_s3, ok_s4, ok_s5, ok_s6, ins_s7;
	logic [61:0]  val_s2 [3];
	logic [61:0]  val_s3 [3];
	logic [61:0]  val_s4 [3];
	logic [61:0]  ll_s3 [3];
	logic [61:0]  ll_s4 [3];
	logic [61:0]  ll_s5 [3];
	logic [61:0]  hl_s4 [3];
	logic [61:0]  hl_s5 [3];
	logic [61:0]  hh_s5 [3];
	logic [123:0] sq_s6 [3];

	// Offsets and magnitudes
	always_comb begin
		dx  = {qx[31], qx} - {cx[31], cx};
		dy  = {qy[31], qy} - {cy[31], cy};
		adx = dx[32] ? 33'd0 - dx : dx;
		ady = dy[32] ? 33'd0 - dy : dy;
	end

	always_ff @(posedge clk) begin
		// box and zero radius
		ok_s1 <= (adx <= {2'b0, rx}) && (ady <= {2'b0, ry}) && (rx != '0) && (ry != '0);
		a_s1  <= adx[30:0];
		b_s1  <= ady[30:0];
		// u = a*ry, v = b*rx, w = rx*ry
		val_s2[0] <= a_s1 * ry;
		val_s2[1] <= b_s1 * rx;
		val_s2[2] <= rx * ry;
		ok_s2 <= ok_s1;
		// squares from 31-bit halves, one partial product per stage
		for (int j = 0; j < 3; j++) begin
			ll_s3[j]  <= val_s2[j][30:0] * val_s2[j][30:0];
			val_s3[j] <= val_s2[j];
			hl_s4[j]  <= val_s3[j][61:31] * val_s3[j][30:0];
			ll_s4[j]  <= ll_s3[j];
			val_s4[j] <= val_s3[j];
			hh_s5[j]  <= val_s4[j][61:31] * val_s4[j][61:31];
			hl_s5[j]  <= hl_s4[j];
			ll_s5[j]  <= ll_s4[j];
			sq_s6[j]  <= {hh_s5[j], 62'b0} + {30'b0, hl_s5[j], 32'b0} + {62'b0, ll_s5[j]};
		end
		ok_s3 <= ok_s2;
		ok_s4 <= ok_s3;
		ok_s5 <= ok_s4;
		ok_s6 <= ok_s5;
		ins_s7 <= ok_s6 && (({1'b0, sq_s6[0]} + {1'b0, sq_s6[1]}) <= {1'b0, sq_s6[2]});
	end

	assign hit = ins_s7;

endmodule

@@ rtl/core/ellipse_point_and_containment.sv @@
// Top level: ellipse perimeter point generator and point containment test.
//
//  channel   signals                                    handshake
//  input     mode step_index precision_factor query_*   start & !busy
//  config    cfg_index cfg_data                         cfg_valid & cfg_ready
//  result    point_x point_y inside_res                 done, one cycle
//
// One item per clock; busy is always low and cfg_ready always high.
// Both modes take the same path: 48 divider cells for the turn phase,
// 3 angle multiply stages, 16 CORDIC cells and 4 scaling stages.
// Containment runs alongside in 7 stages and joins the divider chain.
// Reset clears the configuration registers and all valid flags; results
// cannot be stalled and leave on done exactly once.
module ellipse_point_and_containment (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 mode,
	input  logic [elpc_pkg::IDX_W-1:0]           step_index,
	input  logic [elpc_pkg::PREC_W-1:0]          precision_factor,
	input  logic signed [elpc_pkg::COORD_W-1:0]  query_x,
	input  logic signed [elpc_pkg::COORD_W-1:0]  query_y,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [31:0]                          cfg_data,
	output logic                                 done,
	output logic signed [elpc_pkg::COORD_W-1:0]  point_x,
	output logic signed [elpc_pkg::COORD_W-1:0]  point_y,
	output logic                                 inside_res
);

	localparam int NW = elpc_pkg::NUM_W;
	localparam int NC = elpc_pkg::CORDIC_STAGES;

	logic signed [elpc_pkg::COORD_W-1:0] center_x_q, center_y_q;
	logic [elpc_pkg::RAD_W-1:0]          radius_x_q, radius_y_q;

	logic                                accept;
	logic [elpc_pkg::PREC_W-1:0]         prec_eff;
	logic [elpc_pkg::CNT_W-1:0]          count_in;
	logic                                cont_ins;

	elpc_pkg::div_t  div_s  [NW+1];
	elpc_pkg::div_t  div_in [NW];
	elpc_pkg::cord_t cord_s [NC+1];

	elpc_pkg::tag_t  tag_a1, tag_a2;
	logic [1:0]      quad_a1, quad_a2;
	logic [elpc_pkg::Q_W-1:0] q_a1;
	logic [61:0]     p1_a1, p1_a2;
	logic [61:0]     p2_full;
	logic [elpc_pkg::Q_W-1:0] p2hi_a2;

	logic signed [elpc_pkg::T_W-1:0]     c_t, s_t, x_e, y_e;
	logic signed [elpc_pkg::COORD_W-1:0] px, py;
	elpc_pkg::tag_t  tag_d [4];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_x_q <= '0;
			radius_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				elpc_pkg::REG_CENTER_X: center_x_q <= $signed(cfg_data);
				elpc_pkg::REG_CENTER_Y: center_y_q <= $signed(cfg_data);
				elpc_pkg::REG_RADIUS_X: radius_x_q <= cfg_data[elpc_pkg::RAD_W-1:0];
				elpc_pkg::REG_RADIUS_Y: radius_y_q <= cfg_data[elpc_pkg::RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Steps per turn; zero precision counts as one
	always_comb begin
		prec_eff = (precision_factor == '0) ? elpc_pkg::PREC_W'(1) : precision_factor;
		count_in = elpc_pkg::CNT_W'(elpc_pkg::SECTORS_PER_TURN) *
		           elpc_pkg::CNT_W'(prec_eff);
		div_s[0].tag.valid  = accept;
		div_s[0].tag.mode   = mode;
		div_s[0].tag.hit    = 1'b0;
		div_s[0].num        = {step_index, elpc_pkg::PH_W'(0)};
		div_s[0].rem        = '0;
		div_s[0].count      = count_in;
	end

	elpc_contain u_contain (
		.clk    (clk),
		.qx     (query_x),
		.qy     (query_y),
		.cx     (center_x_q),
		.cy     (center_y_q),
		.rx     (radius_x_q),
		.ry     (radius_y_q),
		.hit    (cont_ins)
	);

	// Divider chain; containment verdict joins where it is ready
	for (genvar k = 0; k < NW; k++) begin : g_div
		if (k == elpc_pkg::CONT_LAT) begin : g_join
			always_comb begin
				div_in[k] = div_s[k];
				div_in[k].tag.hit = cont_ins;
			end
		end else begin : g_pass
			assign div_in[k] = div_s[k];
		end
		elpc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.d_i    (div_in[k]),
			.d_o    (div_s[k+1])
		);
	end

	assign p2_full = q_a1 * elpc_pkg::TWO_PI_LO;

	// Phase to Q60 angle within the quadrant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_a1    <= '0;
			tag_a2    <= '0;
			cord_s[0] <= '0;
		end else begin
			tag_a1  <= div_s[NW].tag;
			quad_a1 <= div_s[NW].num[elpc_pkg::PH_W-1:elpc_pkg::PH_W-2];
			q_a1    <= div_s[NW].num[elpc_pkg::Q_W-1:0];
			p1_a1   <= div_s[NW].num[elpc_pkg::Q_W-1:0] * elpc_pkg::TWO_PI_HI;
			tag_a2  <= tag_a1;
			quad_a2 <= quad_a1;
			p1_a2   <= p1_a1;
			p2hi_a2 <= p2_full[61:32];
			cord_s[0].tag  <= tag_a2;
			cord_s[0].quad <= quad_a2;
			cord_s[0].x    <= elpc_pkg::GAIN_Q30;
			cord_s[0].y    <= '0;
			cord_s[0].z    <= $signed({2'b0, p1_a2 + 62'(p2hi_a2)});
		end
	end

	// CORDIC chain
	for (genvar k = 0; k < NC; k++) begin : g_cord
		localparam logic signed [elpc_pkg::Z_W-1:0] ATAN_K = elpc_pkg::atan_q60(k);
		elpc_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.c_i    (cord_s[k]),
			.sh     (elpc_pkg::SH_W'(k)),
			.atan   (ATAN_K),
			.c_o    (cord_s[k+1])
		);
	end

	// Quadrant unfolding
	always_comb begin
		x_e = {cord_s[NC].x[elpc_pkg::XY_W-1], cord_s[NC].x};
		y_e = {cord_s[NC].y[elpc_pkg::XY_W-1], cord_s[NC].y};
		unique case (cord_s[NC].quad)
			2'd0: begin c_t = x_e;  s_t = y_e;  end
			2'd1: begin c_t = -y_e; s_t = x_e;  end
			2'd2: begin c_t = -x_e; s_t = -y_e; end
			default: begin c_t = y_e; s_t = -x_e; end
		endcase
	end

	elpc_scale u_scale_x (
		.clk    (clk),
		.r      (radius_x_q),
		.t      (c_t),
		.center (center_x_q),
		.pt     (px)
	);

	elpc_scale u_scale_y (
		.clk    (clk),
		.r      (radius_y_q),
		.t      (s_t),
		.center (center_y_q),
		.pt     (py)
	);

	// Flags follow the scaling lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 4; j++) tag_d[j] <= '0;
		end else begin
			tag_d[0] <= cord_s[NC].tag;
			for (int j = 1; j < 4; j++) tag_d[j] <= tag_d[j-1];
		end
	end

	assign done       = tag_d[3].valid;
	assign point_x    = tag_d[3].mode ? '0 : px;
	assign point_y    = tag_d[3].mode ? '0 : py;
	assign inside_res = tag_d[3].mode & tag_d[3].hit;

endmodule

@@ sim/ellipse_point_and_containment_test.sv @@
// Self-checking testbench for the ellipse point generator and containment test.
`timescale 1ns / 1ps

module ellipse_point_and_containment_test;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int RANDOM_PER_CFG = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic mode = 1'b0;
	logic [elpc_pkg::IDX_W-1:0] step_index = '0;
	logic [elpc_pkg::PREC_W-1:0] precision_factor = '0;
	logic signed [elpc_pkg::COORD_W-1:0] query_x = '0;
	logic signed [elpc_pkg::COORD_W-1:0] query_y = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic done;
	logic signed [elpc_pkg::COORD_W-1:0] point_x;
	logic signed [elpc_pkg::COORD_W-1:0] point_y;
	logic inside_res;

	ellipse_point_and_containment dut (.*);

	always #5 clk = ~clk;

	// Expected result of one item
	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic in;
	} ellipse_result_t;

	// Directed row; known rows carry their result typed in
	typedef struct {
		logic mode;
		logic [15:0] idx;
		logic [7:0] prec;
		logic signed [31:0] qx;
		logic signed [31:0] qy;
		logic rel;
		logic known;
		ellipse_result_t res;
	} stim_row_t;

	ellipse_result_t pending_results[$];
	longint atan_tab[elpc_pkg::CORDIC_STAGES];
	logic signed [31:0] cur_cx = 0, cur_cy = 0;
	logic [30:0] cur_rx = 0, cur_ry = 0;
	int errors = 0;
	int n_items = 0, n_results = 0, n_cfg = 0, n_inside = 0;
	int idle_cycles = 0;

	// Reset-state rows, then rows checked against the predictor after setup
	localparam int N_ROWS = 16;
	localparam int N_KNOWN = 4;
	stim_row_t rows[N_ROWS] = '{
		'{1'b0, 16'd0,     8'd1,   32'sd0, 32'sd0, 1'b0, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
		'{1'b0, 16'd65535, 8'd255, 32'sd0, 32'sd0, 1'b0, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
		'{1'b1, 16'd0,     8'd1,   32'sd0, 32'sd0, 1'b0, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
		'{1'b1, 16'hFFFF,  8'hFF,  32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b1,
			'{32'sd0, 32'sd0, 1'b0}},
		'{1'b0, 16'd0,     8'd1,   32'sd0, 32'sd0, 1'b0, 1'b0, '{0, 0, 0}},
		'{1'b0, 16'd3,     8'd1,   32'sd0, 32'sd0, 1'b0, 1'b0, '{0, 0, 0}},
		'{1'b0, 16'd6,     8'd1,   32'sd0, 32'sd0, 1'b0, 1'b0, '{0, 0, 0}},
		'{1'b0, 16'd9,     8'd1,   32'sd0, 32'sd0, 1'b0, 1'b0, '{0, 0, 0}},
		'{1'b0, 16'd5,     8'd0,   32'sd0, 32'sd0, 1'b0, 1'b0, '{0, 0, 0}},
		'{1'b0, 16'd65535, 8'd255, 32'sd0, 32'sd0, 1'b0, 1'b0, '{0, 0, 0}},
		'{1'b0, 16'd1,     8'd255, 32'sd0, 32'sd0, 1'b0, 1'b0, '{0, 0, 0}},
		'{1'b1, 16'd0,     8'd0,   32'sd0, 32'sd0, 1'b1, 1'b0, '{0, 0, 0}},
		'{1'b1, 16'd0,     8'd0,   32'sd6553600, 32'sd0, 1'b1, 1'b0, '{0, 0, 0}},
		'{1'b1, 16'd0,     8'd0,   32'sd0, -32'sd3276800, 1'b1, 1'b0, '{0, 0, 0}},
		'{1'b1, 16'd0,     8'd0,   32'sd6553601, 32'sd0, 1'b1, 1'b0, '{0, 0, 0}},
		'{1'b1, 16'd0,     8'd0,   32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, '{0, 0, 0}}
	};

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFFFFFF;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	// Perimeter point by fixed-stage CORDIC on a quadrant remainder
	function automatic ellipse_result_t perimeter_point(logic [15:0] idx, logic [7:0] prec);
		ellipse_result_t res;
		longint unsigned count, rmd, phase, q;
		longint x, y, z, c, s, dx, dy;
		logic [1:0] quad;
		count = elpc_pkg::SECTORS_PER_TURN * ((prec == 0) ? 1 : prec);
		rmd = idx % count;
		phase = (rmd << 32) / count;
		quad = phase[31:30];
		q = phase & 64'h3FFFFFFF;
		z = q * 64'h6487ED51 + ((q * 64'h10B4611A) >> 32);
		x = 652032874;
		y = 0;
		for (int i = 0; i < elpc_pkg::CORDIC_STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		case (quad)
			2'd0: begin c = x;  s = y;  end
			2'd1: begin c = -y; s = x;  end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		res.px = clamp32(longint'(cur_cx) + ((longint'(cur_rx) * c + (64'sd1 << 29)) >>> 30));
		res.py = clamp32(longint'(cur_cy) + ((longint'(cur_ry) * s + (64'sd1 << 29)) >>> 30));
		res.in = 1'b0;
		return res;
	endfunction

	// Exact containment: zero radius and bounding box, then dx^2 ry^2 + dy^2 rx^2 <= rx^2 ry^2
	function automatic logic point_inside(logic signed [31:0] qx, logic signed [31:0] qy);
		longint cx, cy, rx, ry, a, b;
		logic [127:0] u, v, w;
		cx = cur_cx; cy = cur_cy; rx = cur_rx; ry = cur_ry;
		if (rx == 0 || ry == 0) return 1'b0;
		if (qx < cx - rx || qx > cx + rx || qy < cy - ry || qy > cy + ry) return 1'b0;
		a = (qx >= cx) ? qx - cx : cx - qx;
		b = (qy >= cy) ? qy - cy : cy - qy;
		u = 128'(a * ry);
		v = 128'(b * rx);
		w = 128'(rx * ry);
		return (u * u + v * v) <= (w * w);
	endfunction

	function automatic ellipse_result_t expected_result(logic m, logic [15:0] idx,
			logic [7:0] prec, logic signed [31:0] qx, logic signed [31:0] qy);
		ellipse_result_t res;
		if (m) begin
			res = '{32'sd0, 32'sd0, point_inside(qx, qy)};
		end else begin
			res = perimeter_point(idx, prec);
		end
		return res;
	endfunction

	// One input transaction; start stays high if the next one follows at once
	task automatic send_item(logic m, logic [15:0] idx, logic [7:0] prec,
			logic signed [31:0] qx, logic signed [31:0] qy, logic known,
			ellipse_result_t typed);
		start <= 1'b1;
		mode <= m;
		step_index <= idx;
		precision_factor <= prec;
		query_x <= qx;
		query_y <= qy;
		pending_results.push_back(known ? typed : expected_result(m, idx, prec, qx, qy));
		@(posedge clk);
		while (busy) @(posedge clk);
		n_items++;
	endtask

	task automatic idle_gap(logic quiet);
		int r, gap;
		r = $urandom_range(0, 99);
		gap = quiet ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Register write transaction; predictor copy follows the same masking
	task automatic write_reg(logic [1:0] index, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (index)
			elpc_pkg::REG_CENTER_X: cur_cx = data;
			elpc_pkg::REG_CENTER_Y: cur_cy = data;
			elpc_pkg::REG_RADIUS_X: cur_rx = data[30:0];
			default: cur_ry = data[30:0];
		endcase
		n_cfg++;
	endtask

	task automatic configure(logic [31:0] cx, logic [31:0] cy, logic [31:0] rx, logic [31:0] ry);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		write_reg(elpc_pkg::REG_CENTER_X, cx);
		write_reg(elpc_pkg::REG_CENTER_Y, cy);
		write_reg(elpc_pkg::REG_RADIUS_X, rx);
		write_reg(elpc_pkg::REG_RADIUS_Y, ry);
	endtask

	function automatic logic signed [31:0] near_coord(logic signed [31:0] c, logic [30:0] rad);
		longint span, off;
		span = longint'(rad) + (longint'(rad) >> 2) + 2;
		off = longint'($urandom) % span;
		if ($urandom_range(0, 1)) off = -off;
		return clamp32(longint'(c) + off);
	endfunction

	// Random items: either mode at random, query points mostly near the ellipse, some anywhere
	task automatic random_items(int count);
		logic m, quiet;
		logic [15:0] idx;
		logic [7:0] prec;
		logic signed [31:0] qx, qy;
		for (int n = 0; n < count; n++) begin
			if (n % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
			m = 1'($urandom_range(0, 1));
			prec = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
			idx = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 60));
			if ($urandom_range(0, 4) == 0) begin
				qx = $urandom;
				qy = $urandom;
			end else begin
				qx = near_coord(cur_cx, cur_rx);
				qy = near_coord(cur_cy, cur_ry);
			end
			send_item(m, idx, prec, qx, qy, 1'b0, '{0, 0, 0});
			idle_gap(quiet);
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		ellipse_result_t exp_res;
		if (arst_n && done) begin
			n_results++;
			if (inside_res) n_inside++;
			if (pending_results.size() == 0) begin
				$error("result with none outstanding");
				errors++;
			end else begin
				exp_res = pending_results.pop_front();
				if (point_x !== exp_res.px) begin
					$error("point_x expected %0d got %0d", exp_res.px, point_x);
					errors++;
				end
				if (point_y !== exp_res.py) begin
					$error("point_y expected %0d got %0d", exp_res.py, point_y);
					errors++;
				end
				if (inside_res !== exp_res.in) begin
					$error("inside_res expected %0d got %0d", exp_res.in, inside_res);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d results outstanding", pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic signed [31:0] qx, qy;
		for (int i = 0; i < elpc_pkg::CORDIC_STAGES; i++) begin
			longint sum;
			longint t;
			if (i == 0) begin
				sum = 64'h3243F6A8885A308D >> 2;
			end else begin
				sum = 0;
				for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
					t = (64'd1 << (60 - i * (2 * k + 1))) / (2 * k + 1);
					sum = k[0] ? sum - t : sum + t;
				end
			end
			atan_tab[i] = sum;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset state first, then a moderate ellipse
		foreach (rows[r]) begin
			if (r == N_KNOWN) begin
				configure(32'h00320000, 32'hFFE00000, 32'd100 << 16, 32'd50 << 16);
			end
			qx = rows[r].rel ? clamp32(longint'(cur_cx) + rows[r].qx) : rows[r].qx;
			qy = rows[r].rel ? clamp32(longint'(cur_cy) + rows[r].qy) : rows[r].qy;
			send_item(rows[r].mode, rows[r].idx, rows[r].prec, qx, qy, rows[r].known, rows[r].res);
			idle_gap(1'b0);
		end
		random_items(RANDOM_PER_CFG);

		// Extreme centres and radii (one radius write with the spare top bit set), then zero radius, small, random
		configure(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF);
		random_items(RANDOM_PER_CFG / 2);
		configure(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000001);
		random_items(RANDOM_PER_CFG / 2);
		configure($urandom, $urandom, 32'h0, $urandom);
		random_items(RANDOM_PER_CFG / 2);
		configure($urandom_range(0, 255), $urandom_range(0, 255), 3, 5);
		random_items(RANDOM_PER_CFG);
		configure($urandom, $urandom, $urandom, $urandom);
		random_items(RANDOM_PER_CFG);

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items, %0d results (%0d inside), %0d register writes",
			n_items, n_results, n_inside, n_cfg);
		$display("configurations: reset, moderate, extreme centres and radii, zero radius");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/elpc_pkg.sv
rtl/core/elpc_div_cell.sv
rtl/core/elpc_cordic_cell.sv
rtl/core/elpc_scale.sv
rtl/core/elpc_contain.sv
rtl/core/ellipse_point_and_containment.sv
sim/ellipse_point_and_containment_test.sv
